// ===== hw/rtl/hthpc_pkg.sv =====
// shared types and constants for the hot tub heater and pump controller
package hthpc_pkg;

   // register indexes on the csr port
   typedef enum logic [2:0] {
      REG_MAX_TEMP        = 3'd0,
      REG_TARGET_TEMP     = 3'd1,
      REG_HYSTERESIS      = 3'd2,
      REG_FIRST_RUN_HOUR  = 3'd3,
      REG_SECOND_RUN_HOUR = 3'd4,
      REG_RUN_MINUTES     = 3'd5,
      REG_LEVEL_LIMIT     = 3'd6,
      REG_ENABLE_FLAGS    = 3'd7
   } hthpc_reg_type;

   // enable flag bit positions
   localparam int unsigned EN_MANUAL_HEAT = 0;
   localparam int unsigned EN_AUTO_FILTER = 1;
   localparam int unsigned EN_AUTO_LEVEL  = 2;

   // unit conversions
   localparam logic [10:0] MIN_PER_HOUR = 11'd60;
   localparam logic [15:0] MS_PER_MIN   = 16'd60000;
   localparam logic [9:0]  MS_PER_SEC   = 10'd1000;

   // configuration as seen by the datapath, scaled values precomputed
   typedef struct packed {
      logic signed [11:0] max_temp;
      logic signed [11:0] target_temp;
      logic [7:0]         hysteresis;
      logic [10:0]        run_minute_a;   // first run hour * 60
      logic [10:0]        run_minute_b;   // second run hour * 60
      logic [26:0]        run_ms;         // run minutes * 60000
      logic [25:0]        drain_limit_ms; // level pump limit seconds * 1000
      logic [2:0]         enable_flags;
   } hthpc_cfg_type;

   // input word, last field in the lowest bits
   typedef struct packed {
      logic               link_timeout_alarm;
      logic               link_usable;
      logic               force_level_pump;
      logic               force_pump;
      logic               master_permit;
      logic               level_high;
      logic               sensor_fault;
      logic               heater_fault;
      logic [10:0]        minute_of_day;
      logic               minute_valid;
      logic signed [11:0] water_temp;
      logic [31:0]        now_ms;
   } hthpc_req_type;

   // result word, last field in the lowest bits, zero fill at the top
   typedef struct packed {
      logic [3:0] pad;
      logic       clock_ok;
      logic       temp_ok;
      logic       level_ok;
      logic       tub_ready;
      logic       drain_timeout;
      logic       general_alarm;
      logic       level_alarm;
      logic       overtemp_alarm;
      logic       alarm_lamp;
      logic       drain_pump_on;
      logic       circ_pump_on;
      logic       heater_on;
   } hthpc_rsp_type;

endpackage

// ===== hw/rtl/hthpc_csr.sv =====
// configuration registers with apb-style access and precomputed scaled values
module hthpc_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output hthpc_pkg::hthpc_cfg_type cfg
);
   import hthpc_pkg::*;

   logic [11:0] max_temp_ff;
   logic [11:0] target_temp_ff;
   logic [7:0]  hysteresis_ff;
   logic [4:0]  first_hour_ff;
   logic [4:0]  second_hour_ff;
   logic [10:0] run_minutes_ff;
   logic [15:0] level_limit_ff;
   logic [2:0]  enable_flags_ff;
   logic [10:0] run_minute_a_ff;
   logic [10:0] run_minute_b_ff;
   logic [26:0] run_ms_ff;
   logic [25:0] drain_limit_ms_ff;

   hthpc_reg_type reg_sel;
   logic          wr_en;

   assign reg_sel = hthpc_reg_type'(csr_paddr[4:2]);
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   // register file, scaled copies updated with the raw value
   always_ff @(posedge clock) begin
      if (reset) begin
         max_temp_ff       <= 12'd400;
         target_temp_ff    <= 12'd380;
         hysteresis_ff     <= 8'd5;
         first_hour_ff     <= 5'd8;
         second_hour_ff    <= 5'd18;
         run_minutes_ff    <= 11'd60;
         level_limit_ff    <= 16'd300;
         enable_flags_ff   <= 3'd0;
         run_minute_a_ff   <= 11'd480;
         run_minute_b_ff   <= 11'd1080;
         run_ms_ff         <= 27'd3600000;
         drain_limit_ms_ff <= 26'd300000;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_MAX_TEMP:        max_temp_ff    <= csr_pwdata[11:0];
            REG_TARGET_TEMP:     target_temp_ff <= csr_pwdata[11:0];
            REG_HYSTERESIS:      hysteresis_ff  <= csr_pwdata[7:0];
            REG_FIRST_RUN_HOUR: begin
               first_hour_ff   <= csr_pwdata[4:0];
               run_minute_a_ff <= {6'd0, csr_pwdata[4:0]} * MIN_PER_HOUR;
            end
            REG_SECOND_RUN_HOUR: begin
               second_hour_ff  <= csr_pwdata[4:0];
               run_minute_b_ff <= {6'd0, csr_pwdata[4:0]} * MIN_PER_HOUR;
            end
            REG_RUN_MINUTES: begin
               run_minutes_ff <= csr_pwdata[10:0];
               run_ms_ff      <= {16'd0, csr_pwdata[10:0]} * {11'd0, MS_PER_MIN};
            end
            REG_LEVEL_LIMIT: begin
               level_limit_ff    <= csr_pwdata[15:0];
               drain_limit_ms_ff <= {10'd0, csr_pwdata[15:0]} * {16'd0, MS_PER_SEC};
            end
            REG_ENABLE_FLAGS:    enable_flags_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         REG_MAX_TEMP:        csr_prdata = {20'd0, max_temp_ff};
         REG_TARGET_TEMP:     csr_prdata = {20'd0, target_temp_ff};
         REG_HYSTERESIS:      csr_prdata = {24'd0, hysteresis_ff};
         REG_FIRST_RUN_HOUR:  csr_prdata = {27'd0, first_hour_ff};
         REG_SECOND_RUN_HOUR: csr_prdata = {27'd0, second_hour_ff};
         REG_RUN_MINUTES:     csr_prdata = {21'd0, run_minutes_ff};
         REG_LEVEL_LIMIT:     csr_prdata = {16'd0, level_limit_ff};
         REG_ENABLE_FLAGS:    csr_prdata = {29'd0, enable_flags_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   assign cfg.max_temp       = signed'(max_temp_ff);
   assign cfg.target_temp    = signed'(target_temp_ff);
   assign cfg.hysteresis     = hysteresis_ff;
   assign cfg.run_minute_a   = run_minute_a_ff;
   assign cfg.run_minute_b   = run_minute_b_ff;
   assign cfg.run_ms         = run_ms_ff;
   assign cfg.drain_limit_ms = drain_limit_ms_ff;
   assign cfg.enable_flags   = enable_flags_ff;

endmodule

// ===== hw/rtl/hot_tub_heater_pump_controller.sv =====
// hot tub heater and pump controller top level
//
//  channel | direction | handshake                  | payload
//  req     | in        | req_tvalid / req_tready    | req_tdata  64 bits, one update
//  rsp     | out       | rsp_tvalid / rsp_tready    | rsp_tdata  16 bits, one result
//  csr     | in        | psel, penable, pwrite      | paddr 5 bits, pwdata/prdata 32
//
// one word in, one word out; a word is taken every cycle when the output is taken
// a word passes through the input register, then decision logic into the result register
// the result register and the input register can both hold a word, so a stalled
// output still lets one more word in before req_tready drops
// synchronous active-high reset clears all controller state and the valid flags of both registers
module hot_tub_heater_pump_controller #(
   parameter int unsigned POSTRUN_MS     = 1800000,
   parameter int unsigned DAY_COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // now_ms[31:0], water_temp[43:32], minute_valid[44], minute_of_day[55:45],
   // heater_fault[56], sensor_fault[57], level_high[58], master_permit[59],
   // force_pump[60], force_level_pump[61], link_usable[62], link_timeout_alarm[63]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // heater_on[0], circ_pump_on[1], drain_pump_on[2], alarm_lamp[3],
   // overtemp_alarm[4], level_alarm[5], general_alarm[6], drain_timeout[7],
   // tub_ready[8], level_ok[9], temp_ok[10], clock_ok[11], zero[15:12]
   output logic [15:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import hthpc_pkg::*;

   localparam logic [31:0] POSTRUN_LIMIT = 32'(POSTRUN_MS);

   hthpc_cfg_type cfg;

   hthpc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .cfg        (cfg)
   );

   assign csr_pready = 1'b1;

   // pipeline control
   logic          in_valid_ff;
   hthpc_req_type in_data_ff;
   logic          out_valid_ff;
   hthpc_rsp_type out_data_ff;
   logic          advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // controller state
   logic                      heater_state_ff, heater_state_in;
   logic                      postrun_active_ff, postrun_active_in;
   logic [31:0]               postrun_start_ff, postrun_start_in;
   logic                      filter_active_ff, filter_active_in;
   logic [31:0]               filter_start_ff, filter_start_in;
   logic [10:0]               prev_minute_ff, prev_minute_in;
   logic                      prev_minute_seen_ff, prev_minute_seen_in;
   logic [DAY_COUNT_BITS-1:0] day_count_ff, day_count_in;
   logic [DAY_COUNT_BITS-1:0] run_done_day_ff [2];
   logic [DAY_COUNT_BITS-1:0] run_done_day_in [2];
   logic [1:0]                run_done_seen_ff, run_done_seen_in;
   logic                      drain_running_ff, drain_running_in;
   logic [31:0]               drain_start_ff, drain_start_in;
   logic                      drain_timeout_ff, drain_timeout_in;
   logic                      prev_level_ff, prev_level_in;
   hthpc_rsp_type             rsp_in;

   // decision logic
   logic               overtemp, local_fault, level_ok, heat_allowed;
   logic               good, at_target, general, drain_on, pump;
   logic signed [13:0] temp_wide, start_threshold;
   logic [10:0]        run_minute [2];
   logic [31:0]        filter_elapsed, postrun_elapsed;

   always_comb begin
      heater_state_in     = heater_state_ff;
      postrun_active_in   = postrun_active_ff;
      postrun_start_in    = postrun_start_ff;
      filter_active_in    = filter_active_ff;
      filter_start_in     = filter_start_ff;
      prev_minute_in      = prev_minute_ff;
      prev_minute_seen_in = prev_minute_seen_ff;
      day_count_in        = day_count_ff;
      run_done_day_in     = run_done_day_ff;
      run_done_seen_in    = run_done_seen_ff;
      drain_running_in    = drain_running_ff;
      drain_start_in      = drain_start_ff;
      drain_timeout_in    = drain_timeout_ff;
      drain_on            = 1'b0;

      // day counting on minute rollover
      if (in_data_ff.minute_valid) begin
         if (prev_minute_seen_ff && (in_data_ff.minute_of_day < prev_minute_ff)) begin
            day_count_in = DAY_COUNT_BITS'(day_count_ff + 1'b1);
         end
         prev_minute_in      = in_data_ff.minute_of_day;
         prev_minute_seen_in = 1'b1;
      end

      // heater with hysteresis and hard overtemp cut
      overtemp        = in_data_ff.water_temp >= cfg.max_temp;
      local_fault     = in_data_ff.heater_fault || in_data_ff.sensor_fault;
      level_ok        = !in_data_ff.level_high;
      heat_allowed    = cfg.enable_flags[EN_MANUAL_HEAT] || in_data_ff.master_permit;
      good            = heat_allowed && !local_fault && level_ok && !overtemp;
      at_target       = in_data_ff.water_temp >= cfg.target_temp;
      temp_wide       = 14'(in_data_ff.water_temp);
      start_threshold = 14'(cfg.target_temp) - signed'({6'd0, cfg.hysteresis});

      if (!heater_state_ff || overtemp) begin
         heater_state_in = 1'b0;
         if (good && (temp_wide < start_threshold)) begin
            heater_state_in   = 1'b1;
            postrun_active_in = 1'b0;
         end
      end else if (!good || at_target) begin
         heater_state_in = 1'b0;
         if (good && at_target) begin
            postrun_active_in = 1'b1;
            postrun_start_in  = in_data_ff.now_ms;
         end else begin
            postrun_active_in = 1'b0;
         end
      end

      // daily filter run starts, each once per day
      run_minute[0] = cfg.run_minute_a;
      run_minute[1] = cfg.run_minute_b;
      if (in_data_ff.minute_valid) begin
         for (int k = 0; k < 2; k++) begin
            if ((in_data_ff.minute_of_day == run_minute[k]) &&
                (!run_done_seen_ff[k] || (run_done_day_ff[k] != day_count_in))) begin
               filter_active_in    = 1'b1;
               filter_start_in     = in_data_ff.now_ms;
               run_done_day_in[k]  = day_count_in;
               run_done_seen_in[k] = 1'b1;
            end
         end
      end

      // run time expiry, wrapping elapsed times
      filter_elapsed  = in_data_ff.now_ms - filter_start_in;
      postrun_elapsed = in_data_ff.now_ms - postrun_start_in;
      if (filter_active_in && (filter_elapsed >= {5'd0, cfg.run_ms})) begin
         filter_active_in = 1'b0;
      end
      if (postrun_active_in && (postrun_elapsed >= POSTRUN_LIMIT)) begin
         postrun_active_in = 1'b0;
      end

      pump = heater_state_in || in_data_ff.force_pump ||
             (cfg.enable_flags[EN_AUTO_FILTER] && filter_active_in) || postrun_active_in;

      general       = local_fault || overtemp || prev_level_ff;
      prev_level_in = in_data_ff.level_high;

      // level pump with run time limit, or forced on with no limit
      if (in_data_ff.force_level_pump) begin
         drain_running_in = 1'b0;
         drain_timeout_in = 1'b0;
         drain_on         = 1'b1;
      end else if (cfg.enable_flags[EN_AUTO_LEVEL] && in_data_ff.level_high) begin
         if (!drain_running_ff) begin
            drain_running_in = 1'b1;
            drain_start_in   = in_data_ff.now_ms;
         end
         if ((in_data_ff.now_ms - drain_start_in) > {6'd0, cfg.drain_limit_ms}) begin
            drain_timeout_in = 1'b1;
            drain_on         = 1'b0;
         end else begin
            drain_on = 1'b1;
         end
      end else begin
         drain_running_in = 1'b0;
         drain_on         = 1'b0;
         if (!in_data_ff.level_high) begin
            drain_timeout_in = 1'b0;
         end
      end

      // result word
      rsp_in.pad            = 4'd0;
      rsp_in.heater_on      = heater_state_in;
      rsp_in.circ_pump_on   = pump;
      rsp_in.drain_pump_on  = drain_on;
      rsp_in.alarm_lamp     = general || in_data_ff.link_timeout_alarm;
      rsp_in.overtemp_alarm = overtemp;
      rsp_in.level_alarm    = in_data_ff.level_high;
      rsp_in.general_alarm  = general;
      rsp_in.drain_timeout  = drain_timeout_in;
      rsp_in.tub_ready      = !local_fault && level_ok && in_data_ff.link_usable;
      rsp_in.level_ok       = level_ok;
      rsp_in.temp_ok        = !in_data_ff.sensor_fault;
      rsp_in.clock_ok       = in_data_ff.minute_valid;
   end

   // input and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= hthpc_req_type'(req_tdata);
      end
      if (advance) begin
         out_data_ff <= rsp_in;
      end
   end

   // controller state update, one word per advance
   always_ff @(posedge clock) begin
      if (reset) begin
         heater_state_ff     <= 1'b0;
         postrun_active_ff   <= 1'b0;
         postrun_start_ff    <= 32'd0;
         filter_active_ff    <= 1'b0;
         filter_start_ff     <= 32'd0;
         prev_minute_ff      <= 11'd0;
         prev_minute_seen_ff <= 1'b0;
         day_count_ff        <= '0;
         run_done_day_ff[0]  <= '0;
         run_done_day_ff[1]  <= '0;
         run_done_seen_ff    <= 2'b00;
         drain_running_ff    <= 1'b0;
         drain_start_ff      <= 32'd0;
         drain_timeout_ff    <= 1'b0;
         prev_level_ff       <= 1'b0;
      end else if (advance) begin
         heater_state_ff     <= heater_state_in;
         postrun_active_ff   <= postrun_active_in;
         postrun_start_ff    <= postrun_start_in;
         filter_active_ff    <= filter_active_in;
         filter_start_ff     <= filter_start_in;
         prev_minute_ff      <= prev_minute_in;
         prev_minute_seen_ff <= prev_minute_seen_in;
         day_count_ff        <= day_count_in;
         run_done_day_ff     <= run_done_day_in;
         run_done_seen_ff    <= run_done_seen_in;
         drain_running_ff    <= drain_running_in;
         drain_start_ff      <= drain_start_in;
         drain_timeout_ff    <= drain_timeout_in;
         prev_level_ff       <= prev_level_in;
      end
   end

endmodule

// ===== hw/rtl/hthpc_checker.sv =====
// port-level checks for the hot tub heater and pump controller, bound to the top level
module hthpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   import hthpc_pkg::*;

   hthpc_rsp_type rsp;
   assign rsp = hthpc_rsp_type'(rsp_tdata);

   // no result word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // heater never drives while at or above the trip
   a_overtemp_cut: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.overtemp_alarm) |-> !rsp.heater_on)
      else $error("heater on during overtemperature");

   // heater only runs with a sound sensor and a normal level
   a_heater_safe: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.heater_on) |-> (rsp.level_ok && rsp.temp_ok))
      else $error("heater on with high level or sensor fault");

   // any general alarm lights the lamp
   a_lamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.general_alarm) |-> rsp.alarm_lamp)
      else $error("general alarm without lamp");

   // stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

endmodule

bind hot_tub_heater_pump_controller hthpc_checker u_hthpc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
